>>> design/cse_pkg.sv
package cse_pkg;

  localparam int LEN_BITS = 12;
  localparam int LEN_W = LEN_BITS + 1;
  localparam int MAX_TOKENS = 6;
  localparam int TOK_CNT_W = $clog2(MAX_TOKENS + 1);
  localparam int TOK_IDX_W = $clog2(MAX_TOKENS);
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_PERCENT      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BREAK_AT_NEWLINE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NEVER_BREAK_NEWLINE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LINE_LEN        = 2'd3;

  localparam logic [7:0] CH_BACKSLASH = 8'h5c;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_NEWLINE   = 8'h0a;
  localparam logic [7:0] CH_PERCENT   = 8'h25;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TILDE     = 8'h7e;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_LOWER_T   = 8'h74;
  localparam logic [7:0] CH_LOWER_N   = 8'h6e;

  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_OPEN  = 2'd1,
    KIND_CLOSE = 2'd2
  } token_kind_t;

  typedef struct packed {
    token_kind_t kind;
    logic [7:0]  ch;
  } token_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [1:0] token_kind;
    logic [7:0] out_char;
    logic       run_last;
  } out_item_t;

endpackage

>>> design/c_string_literal_escaper.sv
// The first token of an accepted byte is offered in the cycle after acceptance.
// A byte yields 1 to 6 tokens, offered one token per cycle while out_ready is high; the
// next byte is accepted in the cycle its predecessor's last token is taken, so
// back-to-back plain bytes flow at one per cycle when out_ready stays high.
// Reset (synchronous, active low) clears the configuration registers, closes any
// open literal, zeroes the body length and empties the output buffer.
module c_string_literal_escaper (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  cse_pkg::in_item_t                     in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output cse_pkg::out_item_t                    out_data,
  input  logic                                  cfg_we,
  input  logic [cse_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [cse_pkg::LEN_BITS-1:0]          cfg_data
);

  logic                          escape_percent_r;
  logic                          break_at_newline_r;
  logic                          never_break_newline_r;
  logic [cse_pkg::LEN_BITS-1:0]  max_line_len_r;

  logic                          literal_open_r;
  logic                          literal_open_nxt;
  logic [cse_pkg::LEN_W-1:0]     body_length_r;
  logic [cse_pkg::LEN_W-1:0]     body_length_nxt;

  cse_pkg::token_t               tok_r   [cse_pkg::MAX_TOKENS];
  cse_pkg::token_t               tok_nxt [cse_pkg::MAX_TOKENS];
  logic [cse_pkg::TOK_CNT_W-1:0] cnt_r;
  logic [cse_pkg::TOK_CNT_W-1:0] cnt_nxt;
  logic [cse_pkg::TOK_IDX_W-1:0] idx_r;
  logic [cse_pkg::TOK_CNT_W-1:0] last_idx;

  logic in_take;
  logic out_take;
  logic is_last_tok;

  logic [7:0]                c;
  logic                      need_open;
  logic [cse_pkg::LEN_W-1:0] base_len;
  logic                      is_pair;
  logic                      is_tab;
  logic                      is_nl;
  logic                      is_pct;
  logic                      is_oct;
  logic                      nl_break;
  logic [cse_pkg::LEN_W-1:0] len_a;
  logic [2:0]                len_add;
  logic [cse_pkg::LEN_W:0]   len_sum;
  logic                      close_len;
  logic                      close_eot;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      escape_percent_r      <= 1'b0;
      break_at_newline_r    <= 1'b0;
      never_break_newline_r <= 1'b0;
      max_line_len_r        <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cse_pkg::REG_ESCAPE_PERCENT:      escape_percent_r      <= cfg_data[0];
        cse_pkg::REG_BREAK_AT_NEWLINE:    break_at_newline_r    <= cfg_data[0];
        cse_pkg::REG_NEVER_BREAK_NEWLINE: never_break_newline_r <= cfg_data[0];
        cse_pkg::REG_MAX_LINE_LEN:        max_line_len_r        <= cfg_data;
        default: ;
      endcase
    end
  end

  // Classification and length update.
  always_comb begin
    c         = in_data.text_byte;
    need_open = !literal_open_r;
    base_len  = need_open ? '0 : body_length_r;
    is_pair   = (c == cse_pkg::CH_BACKSLASH) || (c == cse_pkg::CH_QUOTE);
    is_tab    = (c == cse_pkg::CH_TAB);
    is_nl     = (c == cse_pkg::CH_NEWLINE);
    is_pct    = (c == cse_pkg::CH_PERCENT) && escape_percent_r;
    is_oct    = !is_pair && !is_tab && !is_nl && !is_pct &&
                ((c < cse_pkg::CH_SPACE) || (c > cse_pkg::CH_TILDE));
    nl_break  = is_nl && (break_at_newline_r ||
                (!never_break_newline_r &&
                 (base_len > {2'b00, max_line_len_r[cse_pkg::LEN_BITS-1:1]})));
    len_a     = nl_break ? {1'b0, max_line_len_r} : base_len;
    if (is_oct) begin
      len_add = 3'd4;
    end else if (is_pair || is_tab || is_nl || is_pct) begin
      len_add = 3'd2;
    end else begin
      len_add = 3'd1;
    end
    len_sum = {1'b0, len_a} + {{(cse_pkg::LEN_W - 2){1'b0}}, len_add};
    body_length_nxt = len_sum[cse_pkg::LEN_W] ? '1 : len_sum[cse_pkg::LEN_W-1:0];
    close_len = (max_line_len_r != '0) && (body_length_nxt > {1'b0, max_line_len_r});
    close_eot = in_data.end_of_text && !close_len;
    literal_open_nxt = !(close_len || in_data.end_of_text);
  end

  // Token list for one byte.
  always_comb begin
    cnt_nxt = '0;
    for (int i = 0; i < cse_pkg::MAX_TOKENS; i++) begin
      tok_nxt[i] = '{kind: cse_pkg::KIND_CHAR, ch: 8'h00};
    end
    if (need_open) begin
      tok_nxt[cnt_nxt[cse_pkg::TOK_IDX_W-1:0]] = '{kind: cse_pkg::KIND_OPEN, ch: 8'h00};
      cnt_nxt = cnt_nxt + 1'b1;
    end
    if (is_pair || is_tab || is_nl || is_oct) begin
      tok_nxt[cnt_nxt[cse_pkg::TOK_IDX_W-1:0]] =
        '{kind: cse_pkg::KIND_CHAR, ch: cse_pkg::CH_BACKSLASH};
      cnt_nxt = cnt_nxt + 1'b1;
    end
    if (is_oct) begin
      tok_nxt[cnt_nxt[cse_pkg::TOK_IDX_W-1:0]] =
        '{kind: cse_pkg::KIND_CHAR, ch: cse_pkg::CH_ZERO + {6'b0, c[7:6]}};
      cnt_nxt = cnt_nxt + 1'b1;
      tok_nxt[cnt_nxt[cse_pkg::TOK_IDX_W-1:0]] =
        '{kind: cse_pkg::KIND_CHAR, ch: cse_pkg::CH_ZERO + {5'b0, c[5:3]}};
      cnt_nxt = cnt_nxt + 1'b1;
      tok_nxt[cnt_nxt[cse_pkg::TOK_IDX_W-1:0]] =
        '{kind: cse_pkg::KIND_CHAR, ch: cse_pkg::CH_ZERO + {5'b0, c[2:0]}};
      cnt_nxt = cnt_nxt + 1'b1;
    end else begin
      if (is_pct) begin
        tok_nxt[cnt_nxt[cse_pkg::TOK_IDX_W-1:0]] =
          '{kind: cse_pkg::KIND_CHAR, ch: cse_pkg::CH_PERCENT};
        cnt_nxt = cnt_nxt + 1'b1;
      end
      if (is_tab) begin
        tok_nxt[cnt_nxt[cse_pkg::TOK_IDX_W-1:0]] =
          '{kind: cse_pkg::KIND_CHAR, ch: cse_pkg::CH_LOWER_T};
      end else if (is_nl) begin
        tok_nxt[cnt_nxt[cse_pkg::TOK_IDX_W-1:0]] =
          '{kind: cse_pkg::KIND_CHAR, ch: cse_pkg::CH_LOWER_N};
      end else begin
        tok_nxt[cnt_nxt[cse_pkg::TOK_IDX_W-1:0]] = '{kind: cse_pkg::KIND_CHAR, ch: c};
      end
      cnt_nxt = cnt_nxt + 1'b1;
    end
    if (close_len || close_eot) begin
      tok_nxt[cnt_nxt[cse_pkg::TOK_IDX_W-1:0]] = '{kind: cse_pkg::KIND_CLOSE, ch: 8'h00};
      cnt_nxt = cnt_nxt + 1'b1;
    end
  end

  // Handshake.
  assign out_valid   = (cnt_r != '0);
  assign last_idx    = cnt_r - 1'b1;
  assign is_last_tok = (idx_r == last_idx[cse_pkg::TOK_IDX_W-1:0]);
  assign out_take    = out_valid && out_ready;
  assign in_ready    = !out_valid || (out_take && is_last_tok);
  assign in_take     = in_valid && in_ready;

  assign out_data.token_kind = tok_r[idx_r].kind;
  assign out_data.out_char   = tok_r[idx_r].ch;
  assign out_data.run_last   = is_last_tok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      literal_open_r <= 1'b0;
      body_length_r  <= '0;
      cnt_r          <= '0;
      idx_r          <= '0;
    end else if (in_take) begin
      literal_open_r <= literal_open_nxt;
      body_length_r  <= body_length_nxt;
      cnt_r          <= cnt_nxt;
      idx_r          <= '0;
    end else if (out_take) begin
      if (is_last_tok) begin
        cnt_r <= '0;
        idx_r <= '0;
      end else begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      for (int i = 0; i < cse_pkg::MAX_TOKENS; i++) begin
        tok_r[i] <= tok_nxt[i];
      end
    end
  end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int LEN_BITS = cse_pkg::LEN_BITS;
  localparam int LEN_W = cse_pkg::LEN_W;
  localparam int LEN_CAP = (1 << LEN_W) - 1;
  localparam int CYCLE_LIMIT = 300000;
  localparam int MAX_REPORTS = 10;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  cse_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  cse_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [cse_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [LEN_BITS-1:0] cfg_data = '0;

  // Mirror of the block's configuration and literal state.
  logic pct_mode = 1'b0;
  logic nl_force = 1'b0;
  logic nl_hold = 1'b0;
  logic [LEN_BITS-1:0] line_max = '0;
  logic lit_open = 1'b0;
  logic [LEN_W-1:0] lit_len = '0;

  cse_pkg::out_item_t pending_tokens[$];
  int fault_count = 0;
  int cycle_count = 0;
  logic steady = 1'b0;

  c_string_literal_escaper u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 19);
  end

  function automatic cse_pkg::out_item_t make_token(input cse_pkg::token_kind_t kind,
                                                    input logic [7:0] ch);
    cse_pkg::out_item_t t;
    t.token_kind = kind;
    t.out_char = ch;
    t.run_last = 1'b0;
    return t;
  endfunction

  function automatic logic [LEN_W-1:0] grow(input logic [LEN_W-1:0] len, input int unsigned n);
    int unsigned sum;
    sum = int'(len) + n;
    return (sum > LEN_CAP) ? LEN_W'(LEN_CAP) : LEN_W'(sum);
  endfunction

  task automatic escape_byte(input cse_pkg::in_item_t item);
    logic [7:0] c;
    cse_pkg::out_item_t toks[$];
    c = item.text_byte;
    if (!lit_open) begin
      toks.push_back(make_token(cse_pkg::KIND_OPEN, 8'h00));
      lit_len = '0;
      lit_open = 1'b1;
    end
    if (c == cse_pkg::CH_BACKSLASH || c == cse_pkg::CH_QUOTE) begin
      toks.push_back(make_token(cse_pkg::KIND_CHAR, cse_pkg::CH_BACKSLASH));
      toks.push_back(make_token(cse_pkg::KIND_CHAR, c));
      lit_len = grow(lit_len, 2);
    end else if (c == cse_pkg::CH_TAB) begin
      toks.push_back(make_token(cse_pkg::KIND_CHAR, cse_pkg::CH_BACKSLASH));
      toks.push_back(make_token(cse_pkg::KIND_CHAR, cse_pkg::CH_LOWER_T));
      lit_len = grow(lit_len, 2);
    end else if (c == cse_pkg::CH_NEWLINE) begin
      toks.push_back(make_token(cse_pkg::KIND_CHAR, cse_pkg::CH_BACKSLASH));
      toks.push_back(make_token(cse_pkg::KIND_CHAR, cse_pkg::CH_LOWER_N));
      if (nl_force || (!nl_hold && lit_len > (line_max >> 1))) begin
        lit_len = grow({1'b0, line_max}, 2);
      end else begin
        lit_len = grow(lit_len, 2);
      end
    end else if (c == cse_pkg::CH_PERCENT && pct_mode) begin
      toks.push_back(make_token(cse_pkg::KIND_CHAR, cse_pkg::CH_PERCENT));
      toks.push_back(make_token(cse_pkg::KIND_CHAR, cse_pkg::CH_PERCENT));
      lit_len = grow(lit_len, 2);
    end else if (c < cse_pkg::CH_SPACE || c > cse_pkg::CH_TILDE) begin
      toks.push_back(make_token(cse_pkg::KIND_CHAR, cse_pkg::CH_BACKSLASH));
      toks.push_back(make_token(cse_pkg::KIND_CHAR, cse_pkg::CH_ZERO + {6'b0, c[7:6]}));
      toks.push_back(make_token(cse_pkg::KIND_CHAR, cse_pkg::CH_ZERO + {5'b0, c[5:3]}));
      toks.push_back(make_token(cse_pkg::KIND_CHAR, cse_pkg::CH_ZERO + {5'b0, c[2:0]}));
      lit_len = grow(lit_len, 4);
    end else begin
      toks.push_back(make_token(cse_pkg::KIND_CHAR, c));
      lit_len = grow(lit_len, 1);
    end
    if (line_max != '0 && lit_len > line_max) begin
      toks.push_back(make_token(cse_pkg::KIND_CLOSE, 8'h00));
      lit_open = 1'b0;
    end
    if (item.end_of_text && lit_open) begin
      toks.push_back(make_token(cse_pkg::KIND_CLOSE, 8'h00));
      lit_open = 1'b0;
    end
    toks[toks.size()-1].run_last = 1'b1;
    foreach (toks[i]) pending_tokens.push_back(toks[i]);
  endtask

  function automatic void log_fault(input string what, input cse_pkg::out_item_t want,
                                    input cse_pkg::out_item_t got);
    fault_count++;
    if (fault_count <= MAX_REPORTS) begin
      $display("%s: expected kind %0d char 0x%02h last %0d, got kind %0d char 0x%02h last %0d",
               what, want.token_kind, want.out_char, want.run_last,
               got.token_kind, got.out_char, got.run_last);
    end
  endfunction

  always @(posedge clk) begin
    cse_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_tokens.size() == 0) begin
        log_fault("token with nothing pending", '0, out_data);
      end else begin
        want = pending_tokens.pop_front();
        if (want.token_kind != out_data.token_kind || want.out_char != out_data.out_char ||
            want.run_last != out_data.run_last) begin
          log_fault("token mismatch", want, out_data);
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eot);
    cse_pkg::in_item_t item;
    item.text_byte = b;
    item.end_of_text = eot;
    if (!steady && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    escape_byte(item);
  endtask

  task automatic wait_for_idle();
    in_valid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic pct, input logic force_nl, input logic hold_nl,
                            input logic [LEN_BITS-1:0] maxlen);
    cfg_we <= 1'b1;
    cfg_index <= cse_pkg::REG_ESCAPE_PERCENT;
    cfg_data <= (LEN_BITS'($urandom) << 1) | LEN_BITS'(pct);
    @(posedge clk);
    cfg_index <= cse_pkg::REG_BREAK_AT_NEWLINE;
    cfg_data <= (LEN_BITS'($urandom) << 1) | LEN_BITS'(force_nl);
    @(posedge clk);
    cfg_index <= cse_pkg::REG_NEVER_BREAK_NEWLINE;
    cfg_data <= (LEN_BITS'($urandom) << 1) | LEN_BITS'(hold_nl);
    @(posedge clk);
    cfg_index <= cse_pkg::REG_MAX_LINE_LEN;
    cfg_data <= maxlen;
    @(posedge clk);
    cfg_we <= 1'b0;
    pct_mode = pct;
    nl_force = force_nl;
    nl_hold = hold_nl;
    line_max = maxlen;
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(10))
      0: return cse_pkg::CH_BACKSLASH;
      1: return cse_pkg::CH_QUOTE;
      2: return cse_pkg::CH_TAB;
      3, 4: return cse_pkg::CH_NEWLINE;
      5: return cse_pkg::CH_PERCENT;
      6: return 8'($urandom_range(0, 31));
      7: return 8'($urandom_range(127, 255));
      default: return 8'($urandom_range(32, 126));
    endcase
  endfunction

  task automatic test_escapes();
    logic [7:0] text[$];
    text = {8'h00, 8'hff, cse_pkg::CH_BACKSLASH, cse_pkg::CH_QUOTE, cse_pkg::CH_TAB,
            cse_pkg::CH_NEWLINE, cse_pkg::CH_PERCENT, cse_pkg::CH_SPACE, cse_pkg::CH_TILDE,
            8'h1f, 8'h7f};
    wait_for_idle();
    set_config(1'b1, 1'b0, 1'b0, '0);
    foreach (text[i]) send_byte(text[i], i == text.size() - 1);
    wait_for_idle();
    set_config(1'b0, 1'b0, 1'b0, '0);
    send_byte(cse_pkg::CH_PERCENT, 1'b1);
  endtask

  task automatic test_line_breaks();
    string word;
    wait_for_idle();
    set_config(1'b0, 1'b0, 1'b0, 12'd8);
    word = "abcde";
    for (int i = 0; i < word.len(); i++) send_byte(word[i], 1'b0);
    send_byte(cse_pkg::CH_NEWLINE, 1'b0);
    send_byte("q", 1'b1);
    wait_for_idle();
    set_config(1'b0, 1'b1, 1'b1, 12'd8);
    send_byte(cse_pkg::CH_NEWLINE, 1'b0);
    send_byte("z", 1'b1);
    wait_for_idle();
    set_config(1'b0, 1'b0, 1'b1, 12'd6);
    word = "abcd";
    for (int i = 0; i < word.len(); i++) send_byte(word[i], 1'b0);
    send_byte(cse_pkg::CH_NEWLINE, 1'b0);
    send_byte("w", 1'b1);
    wait_for_idle();
    set_config(1'b1, 1'b0, 1'b0, 12'd1);
    send_byte(8'h01, 1'b1);
  endtask

  task automatic test_long_literal();
    wait_for_idle();
    set_config(1'b0, 1'b0, 1'b0, '0);
    repeat (24) send_byte(8'($urandom_range(127, 255)), 1'b0);
    wait_for_idle();
    set_config(1'b0, 1'b0, 1'b0, 12'd90);
    send_byte("x", 1'b1);
  endtask

  task automatic test_random_texts();
    logic [LEN_BITS-1:0] limits[6];
    int sent;
    int len;
    logic paused;
    limits = '{12'd0, 12'd1, 12'd4095, LEN_BITS'($urandom_range(2, 12)),
               LEN_BITS'($urandom_range(13, 60)), LEN_BITS'($urandom_range(2, 30))};
    paused = 1'b0;
    for (int p = 0; p < 6; p++) begin
      wait_for_idle();
      set_config(1'($urandom), 1'($urandom_range(3) == 0), 1'($urandom), limits[p]);
      steady = (p == 3);
      sent = 0;
      while (sent < 60) begin
        len = $urandom_range(1, 16);
        for (int i = 0; i < len; i++) begin
          send_byte(pick_byte(), i == len - 1 || $urandom_range(19) == 0);
        end
        sent += len;
        if (p == 4 && !paused && sent >= 30) begin
          wait_for_idle();
          paused = 1'b1;
        end
      end
    end
    wait_for_idle();
    steady = 1'b0;
  endtask

  initial begin
    rst_n <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_escapes();
    test_line_breaks();
    test_long_literal();
    test_random_texts();
    wait_for_idle();
    repeat (10) @(posedge clk);
    if (fault_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
